// ===== hdl/rtpacct_pkg.sv =====
// Shared constants, codes and helper functions for the RTP packet accounting block.
`timescale 1ns / 1ps
package rtpacct_pkg;

    localparam int COUNTER_BITS = 48;
    localparam int OUT_CNT_W    = 48;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 320;

    localparam int PT_W       = 7;
    localparam int RATE_W     = 19;
    localparam int CFG_DATA_W = 19;
    localparam int SEQ_W      = 16;
    localparam int BYTES_W    = 16;
    localparam int TS_W       = 32;
    localparam int LOST_W     = 15;
    localparam int PTIME_W    = 62;
    localparam int NS_W       = 30;

    localparam logic [0:0] CFG_EXPECTED_PT = 1'd0;
    localparam logic [0:0] CFG_SAMPLE_RATE = 1'd1;

    localparam logic [PT_W-1:0]   PT_RESET   = 7'd96;
    localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;

    localparam logic [0:0] OP_PACKET = 1'b0;
    localparam logic [0:0] OP_CLEAR  = 1'b1;

    localparam logic [1:0] RTP_VERSION_OK = 2'd2;
    localparam logic [BYTES_W-1:0] MAX_PAYLOAD = 16'd1500;
    localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

    localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_CLEARED   = 2'd2;

    localparam logic [1:0] CLS_NONE     = 2'd0;
    localparam logic [1:0] CLS_IN_ORDER = 2'd1;
    localparam logic [1:0] CLS_GAP      = 2'd2;
    localparam logic [1:0] CLS_REORDER  = 2'd3;

    function automatic logic [COUNTER_BITS-1:0] sat_add(
        input logic [COUNTER_BITS-1:0] v,
        input logic [BYTES_W-1:0]      a
    );
        logic [COUNTER_BITS:0] s;
        s = {1'b0, v} + (COUNTER_BITS+1)'(a);
        return s[COUNTER_BITS] ? {COUNTER_BITS{1'b1}} : s[COUNTER_BITS-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNTER_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

// ===== hdl/rtp_packet_accounting.sv =====
// Top level of the RTP receive packet accounting block.
//
// Input stream: one beat per RTP header or clear command. s_tuser is the op
// (0 packet, 1 clear statistics). Output stream: one beat per input beat with
// the status in m_tuser and the per-packet results and counters in m_tdata.
// Configuration: cfg_we/cfg_index/cfg_wdata write the expected payload type
// (index 0) and the sample rate in Hz (index 1); write only while idle.
//
// Clear commands, malformed packets, the first timed packet and packets with
// sample rate 0 go from the accepting edge straight to the done state, which
// loads the output register once it is free. Packets that need a presentation
// time first pass the 32x30 multiply into the divider, the bit-serial divider
// and the capture of the quotient, then the output load.
// s_tready is high only in the idle state, so the block takes no new beat
// until the previous result has been loaded into the output register.
// The result sits in an output register, held while m_tready is low; a later
// result then waits in the done state until the held one is taken.
// Reset (aresetn low, synchronous) clears all counters, sequence and
// timestamp tracking and the connection flag, and restores the registers
// to payload type 96 and 48000 Hz.
`timescale 1ns / 1ps
module rtp_packet_accounting (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] rtp_version, [8:2] payload_type, [24:9] payload_bytes,
    // [40:25] sequence_number, [72:41] media_timestamp, [79:73] zero
    input  logic [rtpacct_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] op
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] sequence_class, [16:2] lost_in_gap, [17] first_of_stream,
    // [79:18] presentation_time, [127:80] received_count, [175:128] lost_count,
    // [223:176] out_of_order_count, [271:224] malformed_count, [319:272] byte_count
    output logic [rtpacct_pkg::M_DATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [1:0]                         m_tuser,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [rtpacct_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rtpacct_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [PT_W-1:0]         exp_pt_reg;
    logic [RATE_W-1:0]       rate_reg;

    logic [SEQ_W-1:0]        last_seq_reg, last_seq_next;
    logic [COUNTER_BITS-1:0] rcv_reg, rcv_next;
    logic [COUNTER_BITS-1:0] lost_reg, lost_next;
    logic [COUNTER_BITS-1:0] ooo_reg, ooo_next;
    logic [COUNTER_BITS-1:0] bad_reg, bad_next;
    logic [COUNTER_BITS-1:0] bytes_reg, bytes_next;
    logic [TS_W-1:0]         base_ts_reg, base_ts_next;
    logic                    base_valid_reg, base_valid_next;
    logic                    connected_reg, connected_next;

    logic [1:0]              status_reg, status_next;
    logic [1:0]              cls_reg, cls_next;
    logic [LOST_W-1:0]       gap_reg, gap_next;
    logic                    first_reg, first_next;
    logic [PTIME_W-1:0]      ptime_reg, ptime_next;
    logic [TS_W-1:0]         delta_reg, delta_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [1:0]              m_tuser_reg, m_tuser_next;

    logic [1:0]              in_ver;
    logic [PT_W-1:0]         in_pt;
    logic [BYTES_W-1:0]      in_bytes;
    logic [SEQ_W-1:0]        in_seq;
    logic [TS_W-1:0]         in_ts;
    logic [SEQ_W-1:0]        seq_diff;
    logic                    malformed;
    logic                    accept;
    logic                    out_free;

    logic                    div_start;
    logic                    div_done;
    logic [PTIME_W-1:0]      div_quotient;
    logic [PTIME_W-1:0]      product;

    assign in_ver   = s_tdata[1:0];
    assign in_pt    = s_tdata[8:2];
    assign in_bytes = s_tdata[24:9];
    assign in_seq   = s_tdata[40:25];
    assign in_ts    = s_tdata[72:41];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign seq_diff = in_seq - (last_seq_reg + 1'b1);
    assign malformed = (in_ver != RTP_VERSION_OK) || (in_pt != exp_pt_reg) ||
                       (in_bytes == '0) || (in_bytes > MAX_PAYLOAD);

    assign product   = PTIME_W'(delta_reg) * PTIME_W'(NS_PER_S);
    assign div_start = (state_reg == ST_MUL);

    rtpacct_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next      = state_reg;
        last_seq_next   = last_seq_reg;
        rcv_next        = rcv_reg;
        lost_next       = lost_reg;
        ooo_next        = ooo_reg;
        bad_next        = bad_reg;
        bytes_next      = bytes_reg;
        base_ts_next    = base_ts_reg;
        base_valid_next = base_valid_reg;
        connected_next  = connected_reg;
        status_next     = status_reg;
        cls_next        = cls_reg;
        gap_next        = gap_reg;
        first_next      = first_reg;
        ptime_next      = ptime_reg;
        delta_next      = delta_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next  = ST_DONE;
                    cls_next    = CLS_NONE;
                    gap_next    = '0;
                    first_next  = 1'b0;
                    ptime_next  = '0;
                    if (s_tuser == OP_CLEAR) begin
                        status_next     = STATUS_CLEARED;
                        last_seq_next   = '0;
                        rcv_next        = '0;
                        lost_next       = '0;
                        ooo_next        = '0;
                        bad_next        = '0;
                        bytes_next      = '0;
                        base_ts_next    = '0;
                        base_valid_next = 1'b0;
                    end else if (malformed) begin
                        status_next = STATUS_MALFORMED;
                        bad_next    = sat_add(bad_reg, BYTES_W'(1));
                    end else begin
                        status_next = STATUS_ACCEPTED;
                        if (!connected_reg) begin
                            connected_next = 1'b1;
                            first_next     = 1'b1;
                        end
                        if (rcv_reg != '0) begin
                            if (seq_diff == '0) begin
                                cls_next = CLS_IN_ORDER;
                            end else if (!seq_diff[SEQ_W-1]) begin
                                cls_next  = CLS_GAP;
                                gap_next  = seq_diff[LOST_W-1:0];
                                lost_next = sat_add(lost_reg, seq_diff);
                            end else begin
                                cls_next = CLS_REORDER;
                                ooo_next = sat_add(ooo_reg, BYTES_W'(1));
                            end
                        end
                        last_seq_next = in_seq;
                        rcv_next      = sat_add(rcv_reg, BYTES_W'(1));
                        bytes_next    = sat_add(bytes_reg, in_bytes);
                        if (rate_reg != '0) begin
                            if (base_valid_reg) begin
                                delta_next = in_ts - base_ts_reg;
                                state_next = ST_MUL;
                            end else begin
                                base_ts_next    = in_ts;
                                base_valid_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    ptime_next = div_quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {cnt_out(bytes_reg), cnt_out(bad_reg), cnt_out(ooo_reg),
                                     cnt_out(lost_reg), cnt_out(rcv_reg), ptime_reg,
                                     first_reg, gap_reg, cls_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            exp_pt_reg     <= PT_RESET;
            rate_reg       <= RATE_RESET;
            last_seq_reg   <= '0;
            rcv_reg        <= '0;
            lost_reg       <= '0;
            ooo_reg        <= '0;
            bad_reg        <= '0;
            bytes_reg      <= '0;
            base_ts_reg    <= '0;
            base_valid_reg <= 1'b0;
            connected_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_seq_reg   <= last_seq_next;
            rcv_reg        <= rcv_next;
            lost_reg       <= lost_next;
            ooo_reg        <= ooo_next;
            bad_reg        <= bad_next;
            bytes_reg      <= bytes_next;
            base_ts_reg    <= base_ts_next;
            base_valid_reg <= base_valid_next;
            connected_reg  <= connected_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EXPECTED_PT: exp_pt_reg <= cfg_wdata[PT_W-1:0];
                    CFG_SAMPLE_RATE: rate_reg   <= cfg_wdata[RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        status_reg  <= status_next;
        cls_reg     <= cls_next;
        gap_reg     <= gap_next;
        first_reg   <= first_next;
        ptime_reg   <= ptime_next;
        delta_reg   <= delta_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/rtpacct_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rtpacct_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [rtpacct_pkg::PTIME_W-1:0]   dividend,
    input  logic [rtpacct_pkg::RATE_W-1:0]    divisor,
    output logic                              done,
    output logic [rtpacct_pkg::PTIME_W-1:0]   quotient
);
    import rtpacct_pkg::*;

    localparam int CNT_W = $clog2(PTIME_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PTIME_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [PTIME_W-1:0]   quo_reg, quo_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [RATE_W-1:0]    dvs_reg, dvs_next;
    logic [RATE_W:0]      trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[PTIME_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? RATE_W'(trial - {1'b0, dvs_reg}) : trial[RATE_W-1:0];
            quo_next = {quo_reg[PTIME_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/rtpacct_checker.sv =====
// Port-level checks for the RTP packet accounting block, bound to the top level.
`timescale 1ns / 1ps
module rtpacct_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rtpacct_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                       m_tuser
);
    import rtpacct_pkg::*;

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken a beat right after an accepted beat");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_CLEARED |-> m_tdata == '0)
        else $error("clear result carries nonzero fields");

    a_malformed_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_MALFORMED |-> m_tdata[79:0] == '0)
        else $error("malformed result carries packet fields");

endmodule

bind rtp_packet_accounting rtpacct_checker u_rtpacct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/rtp_packet_accounting_test.sv =====
// Self-checking stream bench for rtp_packet_accounting: directed table, random streams, predictor.
`timescale 1ns / 1ps
module rtp_packet_accounting_test;
    import rtpacct_pkg::*;

    typedef struct {
        logic [0:0]         op;
        logic [1:0]         ver;
        logic [PT_W-1:0]    pt;
        logic [BYTES_W-1:0] nbytes;
        logic [SEQ_W-1:0]   seq;
        logic [TS_W-1:0]    ts;
    } rtp_header_t;

    typedef struct {
        logic [1:0]           status;
        logic [1:0]           cls;
        logic [LOST_W-1:0]    lost;
        logic                 first;
        logic [PTIME_W-1:0]   ptime;
        logic [OUT_CNT_W-1:0] rcv;
        logic [OUT_CNT_W-1:0] missing;
        logic [OUT_CNT_W-1:0] reordered;
        logic [OUT_CNT_W-1:0] rejected;
        logic [OUT_CNT_W-1:0] bytes;
    } acct_report_t;

    typedef struct {
        rtp_header_t  hdr;
        bit           typed;
        acct_report_t want;
    } table_row_t;

    localparam logic [COUNTER_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [63:0]             NS_SCALE   = 64'(NS_PER_S);
    localparam int                      QUIET_MAX  = 3000;
    localparam int                      HOLD_BEAT  = 150;
    localparam int                      HOLD_LEN   = 400;
    localparam int                      PHASES     = 6;
    localparam int                      PHASE_LEN  = 97;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state, matches the block after reset
    logic [PT_W-1:0]         cfg_pt    = PT_RESET;
    logic [RATE_W-1:0]       cfg_rate  = RATE_RESET;
    logic [SEQ_W-1:0]        last_seq  = '0;
    logic [COUNTER_BITS-1:0] n_rcv     = '0;
    logic [COUNTER_BITS-1:0] n_missing = '0;
    logic [COUNTER_BITS-1:0] n_reorder = '0;
    logic [COUNTER_BITS-1:0] n_reject  = '0;
    logic [COUNTER_BITS-1:0] n_bytes   = '0;
    logic [TS_W-1:0]         base_ts   = '0;
    logic                    base_ok   = 1'b0;
    logic                    connected = 1'b0;

    acct_report_t pending_reports[$];
    table_row_t   directed_rows[$];

    logic [SEQ_W-1:0] stream_seq;
    logic [TS_W-1:0]  stream_ts;
    bit               tx_burst = 1'b0;
    bit               rx_burst = 1'b0;

    int unsigned mismatches   = 0;
    int unsigned headers_sent = 0;
    int unsigned beats_seen   = 0;
    int unsigned settings     = 1;
    int unsigned quiet_cycles = 0;
    int unsigned seen_in_order, seen_gap, seen_reorder, seen_malformed, seen_clear;

    rtp_packet_accounting DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [COUNTER_BITS-1:0] saturating_sum(
        input logic [COUNTER_BITS-1:0] acc,
        input logic [BYTES_W-1:0]      inc
    );
        if (COUNTER_BITS'(inc) > COUNT_MAX - acc) return COUNT_MAX;
        return acc + COUNTER_BITS'(inc);
    endfunction

    function automatic acct_report_t account_header(input rtp_header_t h);
        acct_report_t     r;
        logic [SEQ_W-1:0] next_seq;
        logic [SEQ_W-1:0] step;
        logic [TS_W-1:0]  delta;
        r = '{default: '0};
        if (h.op == OP_CLEAR) begin
            last_seq  = '0;
            n_rcv     = '0;
            n_missing = '0;
            n_reorder = '0;
            n_reject  = '0;
            n_bytes   = '0;
            base_ts   = '0;
            base_ok   = 1'b0;
            r.status  = STATUS_CLEARED;
        end else if (h.ver != RTP_VERSION_OK || h.pt != cfg_pt || h.nbytes == '0 ||
                     h.nbytes > MAX_PAYLOAD) begin
            n_reject = saturating_sum(n_reject, BYTES_W'(1));
            r.status = STATUS_MALFORMED;
        end else begin
            r.status = STATUS_ACCEPTED;
            if (!connected) begin
                connected = 1'b1;
                r.first   = 1'b1;
            end
            if (n_rcv != '0) begin
                next_seq = last_seq + 1'b1;
                step     = h.seq - next_seq;
                if (step == '0) begin
                    r.cls = CLS_IN_ORDER;
                end else if (!step[SEQ_W-1]) begin
                    r.cls     = CLS_GAP;
                    r.lost    = step[LOST_W-1:0];
                    n_missing = saturating_sum(n_missing, step);
                end else begin
                    r.cls     = CLS_REORDER;
                    n_reorder = saturating_sum(n_reorder, BYTES_W'(1));
                end
            end
            last_seq = h.seq;
            n_rcv    = saturating_sum(n_rcv, BYTES_W'(1));
            n_bytes  = saturating_sum(n_bytes, h.nbytes);
            if (cfg_rate != '0) begin
                if (base_ok) begin
                    delta   = h.ts - base_ts;
                    r.ptime = PTIME_W'(({32'd0, delta} * NS_SCALE) / 64'(cfg_rate));
                end else begin
                    base_ts = h.ts;
                    base_ok = 1'b1;
                end
            end
        end
        r.rcv       = n_rcv;
        r.missing   = n_missing;
        r.reordered = n_reorder;
        r.rejected  = n_reject;
        r.bytes     = n_bytes;
        return r;
    endfunction

    function automatic rtp_header_t hdr(input logic [0:0] op, input logic [1:0] ver,
                                        input logic [PT_W-1:0] pt,
                                        input logic [BYTES_W-1:0] nbytes,
                                        input logic [SEQ_W-1:0] seq, input logic [TS_W-1:0] ts);
        rtp_header_t h;
        h.op = op; h.ver = ver; h.pt = pt; h.nbytes = nbytes; h.seq = seq; h.ts = ts;
        return h;
    endfunction

    function automatic acct_report_t rep(input logic [1:0] status, input logic [1:0] cls,
                                         input logic [63:0] lost, input logic first,
                                         input logic [63:0] ptime, input logic [63:0] rcv,
                                         input logic [63:0] missing, input logic [63:0] reordered,
                                         input logic [63:0] rejected, input logic [63:0] bytes);
        acct_report_t r;
        r.status = status; r.cls = cls; r.lost = lost[LOST_W-1:0]; r.first = first;
        r.ptime = ptime[PTIME_W-1:0]; r.rcv = rcv[OUT_CNT_W-1:0];
        r.missing = missing[OUT_CNT_W-1:0]; r.reordered = reordered[OUT_CNT_W-1:0];
        r.rejected = rejected[OUT_CNT_W-1:0]; r.bytes = bytes[OUT_CNT_W-1:0];
        return r;
    endfunction

    task automatic add_row(input rtp_header_t h, input bit typed, input acct_report_t w);
        table_row_t row;
        row.hdr   = h;
        row.typed = typed;
        row.want  = w;
        directed_rows.push_back(row);
    endtask

    task automatic send_header(input rtp_header_t h, input bit typed, input acct_report_t w);
        int           gap;
        acct_report_t predicted;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= h.op;
        s_tdata  <= {7'd0, h.ts, h.seq, h.nbytes, h.pt, h.ver};
        do @(posedge aclk); while (!s_tready);
        predicted = account_header(h);
        pending_reports.push_back(typed ? w : predicted);
        headers_sent++;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_EXPECTED_PT) cfg_pt = val[PT_W-1:0];
        else cfg_rate = val[RATE_W-1:0];
    endtask

    // mostly well-formed streams with gaps, reorders and timestamp jumps; some junk and clears
    task automatic send_random_headers(input int count);
        rtp_header_t  h;
        acct_report_t unused;
        int           pick;
        int           v;
        unused = '{default: '0};
        repeat (count) begin
            pick = $urandom_range(0, 99);
            h = hdr(OP_PACKET, RTP_VERSION_OK, cfg_pt, BYTES_W'($urandom_range(1, 1500)),
                    SEQ_W'($urandom), $urandom);
            if (pick < 3) begin
                h.op  = OP_CLEAR;
                h.ver = 2'($urandom);
                h.pt  = PT_W'($urandom);
            end else if (pick < 15) begin
                case ($urandom_range(0, 4))
                    0: begin
                        v = $urandom_range(0, 2);
                        h.ver = (v == 2) ? 2'd3 : 2'(v);
                    end
                    1: h.pt = cfg_pt ^ PT_W'($urandom_range(1, 127));
                    2: h.nbytes = '0;
                    3: h.nbytes = BYTES_W'($urandom_range(1501, 65535));
                    default: begin
                        h.ver    = 2'($urandom);
                        h.pt     = PT_W'($urandom);
                        h.nbytes = BYTES_W'($urandom);
                    end
                endcase
            end else begin
                case ($urandom_range(0, 9))
                    0: h.nbytes = 16'd1;
                    1: h.nbytes = MAX_PAYLOAD;
                    default: ;
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 78) h.seq = stream_seq;
                else if (pick < 86) h.seq = stream_seq + SEQ_W'($urandom_range(1, 30));
                else if (pick < 90) h.seq = stream_seq + SEQ_W'($urandom_range(31, 32767));
                else if (pick < 94) h.seq = stream_seq - 1'b1;
                else if (pick < 97) h.seq = stream_seq - SEQ_W'($urandom_range(2, 50));
                stream_seq = h.seq + 1'b1;
                pick = $urandom_range(0, 19);
                if (pick == 1) h.ts = stream_ts - TS_W'($urandom_range(1, 1000));
                else if (pick != 0) h.ts = stream_ts + TS_W'($urandom_range(0, 4096));
                stream_ts = h.ts;
            end
            send_header(h, 1'b0, unused);
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off to fill the block
    initial begin
        int           hold;
        acct_report_t want;
        forever begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 11);
            if (beats_seen == HOLD_BEAT) hold = HOLD_LEN;
            repeat (hold) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            beats_seen++;
            if (pending_reports.size() == 0) begin
                $error("result beat with no packet outstanding");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("sequence_class", want.cls, m_tdata[1:0]);
                check_field("lost_in_gap", want.lost, m_tdata[16:2]);
                check_field("first_of_stream", want.first, m_tdata[17]);
                check_field("presentation_time", want.ptime, m_tdata[79:18]);
                check_field("received_count", want.rcv, m_tdata[127:80]);
                check_field("lost_count", want.missing, m_tdata[175:128]);
                check_field("out_of_order_count", want.reordered, m_tdata[223:176]);
                check_field("malformed_count", want.rejected, m_tdata[271:224]);
                check_field("byte_count", want.bytes, m_tdata[319:272]);
                if (want.status == STATUS_CLEARED) seen_clear++;
                else if (want.status == STATUS_MALFORMED) seen_malformed++;
                else if (want.cls == CLS_IN_ORDER) seen_in_order++;
                else if (want.cls == CLS_GAP) seen_gap++;
                else if (want.cls == CLS_REORDER) seen_reorder++;
            end
        end
    end

    initial begin
        logic [PT_W-1:0]   phase_pt[PHASES];
        logic [RATE_W-1:0] phase_rate[PHASES];
        acct_report_t      none;
        none = '{default: '0};

        // defaults after reset: payload type 96, 48000 Hz
        add_row(hdr(OP_PACKET, 2'd0, 7'd96, 16'd100, 16'd5, 32'd0), 1'b1,
                rep(STATUS_MALFORMED, CLS_NONE, 0, 0, 0, 0, 0, 0, 1, 0));
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd1, 16'hFFFF, 32'hFFFF_FF00), 1'b1,
                rep(STATUS_ACCEPTED, CLS_NONE, 0, 1, 0, 1, 0, 0, 1, 1));
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd1500, 16'h0000, 32'h0000_BA80), 1'b1,
                rep(STATUS_ACCEPTED, CLS_IN_ORDER, 0, 0, 1_000_000_000, 2, 0, 0, 1, 1501));
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd700, 16'h8000, 32'h0001_7600), 1'b1,
                rep(STATUS_ACCEPTED, CLS_GAP, 32767, 0, 2_000_000_000, 3, 32767, 0, 1, 2201));
        // half-range step counts as out of order, then a duplicate
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd64, 16'h0001, 32'h1234_5678), 1'b0, none);
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd64, 16'h0001, 32'h1234_5679), 1'b0, none);
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd0, 16'h0002, 32'h0), 1'b0, none);
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd1501, 16'h0002, 32'h0), 1'b0, none);
        add_row(hdr(OP_PACKET, 2'd3, 7'd127, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, none);
        add_row(hdr(OP_PACKET, 2'd2, 7'd97, 16'd10, 16'h0002, 32'h0), 1'b0, none);
        add_row(hdr(OP_PACKET, 2'd1, 7'd96, 16'd10, 16'h0002, 32'h0), 1'b0, none);
        // timestamp one behind the base: largest wrap-safe delta
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd20, 16'h0002, 32'hFFFF_FEFF), 1'b0, none);
        add_row(hdr(OP_CLEAR, 2'd3, 7'd127, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
                rep(STATUS_CLEARED, CLS_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
        // connection survives a clear, so no first flag here
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd1500, 16'h1234, 32'h0), 1'b1,
                rep(STATUS_ACCEPTED, CLS_NONE, 0, 0, 0, 1, 0, 0, 0, 1500));
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd33, 16'h1235, 32'd48), 1'b0, none);
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd33, 16'h1237, 32'h8000_0000), 1'b0, none);
        add_row(hdr(OP_CLEAR, 2'd0, 7'd0, 16'd0, 16'd0, 32'd0), 1'b1,
                rep(STATUS_CLEARED, CLS_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(hdr(OP_PACKET, 2'd2, 7'd96, 16'd1, 16'd0, 32'd0), 1'b0, none);

        phase_pt[0] = 7'd127;  phase_rate[0] = 19'd1;
        phase_pt[1] = 7'd0;    phase_rate[1] = 19'd0;
        phase_pt[2] = 7'd96;   phase_rate[2] = 19'd384000;
        phase_pt[3] = PT_W'($urandom_range(0, 127));
        phase_rate[3] = RATE_W'($urandom_range(1, 384000));
        phase_pt[4] = PT_W'($urandom_range(0, 127));
        phase_rate[4] = 19'd8000;
        phase_pt[5] = 7'd96;   phase_rate[5] = 19'd48000;

        stream_seq = SEQ_W'($urandom);
        stream_ts  = $urandom;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].want);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_EXPECTED_PT, CFG_DATA_W'(phase_pt[p]));
            write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(phase_rate[p]));
            settings++;
            send_random_headers(PHASE_LEN);
            drain();
        end

        repeat (80) @(posedge aclk);

        $display("covered %0d headers, %0d result beats, %0d register settings",
                 headers_sent, beats_seen, settings);
        $display("in order %0d, gaps %0d, reordered %0d, malformed %0d, clears %0d",
                 seen_in_order, seen_gap, seen_reorder, seen_malformed, seen_clear);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
